[design/c8ie_pkg.sv]
// Shared types, codes and constants of the CHIP-8 instruction execute block.
package c8ie_pkg;

    localparam int NUM_REGS            = 16;
    localparam int STACK_DEPTH_DEFAULT = 16;
    localparam logic [11:0] PC_RESET   = 12'h200;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_EXTERNAL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] instruction;
        logic [7:0]  random_byte;
        logic [15:0] keys_down;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] next_pc;
        logic [11:0] index_addr;
        logic [7:0]  vx_value;
        logic [7:0]  vy_value;
    } out_item_t;

    typedef struct packed {
        logic       we;
        logic [3:0] addr;
        logic [7:0] data;
        logic       flag_we;
        logic       flag;
    } rf_wr_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [11:0] data;
    } stk_ctl_t;

    typedef struct packed {
        out_item_t   res;
        rf_wr_t      rf;
        stk_ctl_t    stk;
        logic [11:0] index_next;
        logic [7:0]  delay_next;
        logic [7:0]  sound_next;
    } exec_t;

endpackage

[design/c8ie_regfile.sv]
// General register file: synchronous memory with V0 and VF held in flops.
module c8ie_regfile (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [3:0]       rd_addr_x,
    input  logic [3:0]       rd_addr_y,
    input  c8ie_pkg::rf_wr_t wr,
    output logic [7:0]       vx,
    output logic [7:0]       vy,
    output logic [7:0]       v0
);

    logic [7:0]                    mem [c8ie_pkg::NUM_REGS];
    logic [c8ie_pkg::NUM_REGS-1:0] vld_reg;
    logic [7:0]                    v0_reg;
    logic [7:0]                    vf_reg;
    logic                          lw_valid_reg;
    logic [3:0]                    lw_addr_reg;
    logic [7:0]                    lw_data_reg;
    logic [3:0]                    ax_reg;
    logic [3:0]                    ay_reg;
    logic [7:0]                    rdx_reg;
    logic [7:0]                    rdy_reg;
    logic                          mem_we;

    assign mem_we = wr.we && (wr.addr != 4'h0) && (wr.addr != 4'hF);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rdx_reg <= mem[rd_addr_x];
            rdy_reg <= mem[rd_addr_y];
            ax_reg  <= rd_addr_x;
            ay_reg  <= rd_addr_y;
        end
        if (mem_we) begin
            lw_addr_reg <= wr.addr;
            lw_data_reg <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            v0_reg       <= 8'h00;
            vf_reg       <= 8'h00;
            lw_valid_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[wr.addr] <= 1'b1;
                lw_valid_reg     <= 1'b1;
            end
            if (wr.we && (wr.addr == 4'h0)) begin
                v0_reg <= wr.data;
            end
            if (wr.we && (wr.addr == 4'hF)) begin
                vf_reg <= wr.data;
            end else if (wr.flag_we) begin
                vf_reg <= {7'b0000000, wr.flag};
            end
        end
    end

    function automatic logic [7:0] pick(input logic [3:0] a, input logic [7:0] rd);
        logic [7:0] v;
        if (a == 4'h0) begin
            v = v0_reg;
        end else if (a == 4'hF) begin
            v = vf_reg;
        end else if (lw_valid_reg && (lw_addr_reg == a)) begin
            v = lw_data_reg;
        end else if (vld_reg[a]) begin
            v = rd;
        end else begin
            v = 8'h00;
        end
        return v;
    endfunction

    always_comb begin
        vx = pick(ax_reg, rdx_reg);
        vy = pick(ay_reg, rdy_reg);
    end

    assign v0 = v0_reg;

endmodule

[design/c8ie_stack.sv]
// Return stack: synchronous memory, depth counter and top-of-stack forwarding.
module c8ie_stack #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             rd_en,
    input  c8ie_pkg::stk_ctl_t               ctl,
    output logic [$clog2(STACK_DEPTH+1)-1:0] depth,
    output logic [11:0]                      top
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [11:0]   mem [STACK_DEPTH];
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] rd_depth_reg;
    logic [11:0]   rd_a_reg;
    logic [11:0]   rd_b_reg;
    logic [11:0]   push_data_reg;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[depth_reg[AW-1:0]] <= ctl.data;
            push_data_reg          <= ctl.data;
        end
        if (rd_en) begin
            rd_a_reg     <= mem[depth_m1[AW-1:0]];
            rd_b_reg     <= mem[depth_m2[AW-1:0]];
            rd_depth_reg <= depth_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else if (ctl.push) begin
            depth_reg <= depth_reg + DW'(1);
        end else if (ctl.pop) begin
            depth_reg <= depth_m1;
        end
    end

    always_comb begin
        if (depth_reg == rd_depth_reg) begin
            top = rd_a_reg;
        end else if (depth_reg == rd_depth_reg + DW'(1)) begin
            top = push_data_reg;
        end else begin
            top = rd_b_reg;
        end
    end

    assign depth = depth_reg;

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |-> (depth_reg < DW'(STACK_DEPTH)))
        else $error("push onto a full return stack");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> (depth_reg != '0))
        else $error("pop from an empty return stack");
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.push |=> (depth_reg == $past(depth_reg) + DW'(1)))
        else $error("depth did not advance on push");
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctl.push && !ctl.pop) |=> $stable(depth_reg))
        else $error("depth changed without push or pop");
`endif

endmodule

[design/c8ie_exec.sv]
// Instruction decode and execute logic for the register subset.
module c8ie_exec #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEFAULT
) (
    input  c8ie_pkg::in_item_t               item,
    input  logic [7:0]                       vx,
    input  logic [7:0]                       vy,
    input  logic [7:0]                       v0,
    input  logic [11:0]                      pc,
    input  logic [11:0]                      index,
    input  logic [7:0]                       delay,
    input  logic [7:0]                       sound,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] depth,
    input  logic [11:0]                      top,
    output c8ie_pkg::exec_t                  ex
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;
    localparam logic [3:0] OP_JP_V0   = 4'hB;
    localparam logic [3:0] OP_RND     = 4'hC;
    localparam logic [3:0] OP_DRW     = 4'hD;
    localparam logic [3:0] OP_SKP     = 4'hE;

    localparam logic [3:0] ALU_LD  = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    localparam logic [7:0] KK_SKP   = 8'h9E;
    localparam logic [7:0] KK_SKNP  = 8'hA1;
    localparam logic [7:0] KK_LD_DT = 8'h07;
    localparam logic [7:0] KK_WR_DT = 8'h15;
    localparam logic [7:0] KK_WR_ST = 8'h18;
    localparam logic [7:0] KK_ADD_I = 8'h1E;
    localparam logic [7:0] KK_KEY   = 8'h0A;
    localparam logic [7:0] KK_FONT  = 8'h29;
    localparam logic [7:0] KK_BCD   = 8'h33;
    localparam logic [7:0] KK_STORE = 8'h55;
    localparam logic [7:0] KK_LOAD  = 8'h65;

    localparam logic [11:0] SYS_LOW  = 12'h1FF;
    localparam logic [11:0] SYS_HIGH = 12'hFFF;

    logic [15:0]       ins;
    logic [3:0]        major;
    logic [3:0]        x;
    logic [3:0]        y;
    logic [3:0]        n;
    logic [7:0]        kk;
    logic [11:0]       nnn;
    logic [11:0]       seq;
    logic [11:0]       npc;
    logic [8:0]        sum;
    logic              skip;
    logic              pressed;
    c8ie_pkg::status_t st;
    c8ie_pkg::rf_wr_t  rf;
    c8ie_pkg::stk_ctl_t stk;
    logic [11:0]       idx;
    logic [7:0]        dt;
    logic [7:0]        sdt;

    always_comb begin
        ins     = item.instruction;
        major   = ins[15:12];
        x       = ins[11:8];
        y       = ins[7:4];
        n       = ins[3:0];
        kk      = ins[7:0];
        nnn     = ins[11:0];
        seq     = pc + 12'd2;
        npc     = seq;
        st      = c8ie_pkg::ST_OK;
        skip    = 1'b0;
        sum     = {1'b0, vx} + {1'b0, vy};
        pressed = item.keys_down[vx[3:0]] && (vx[7:4] == 4'h0);
        rf      = '{we: 1'b0, addr: x, data: 8'h00, flag_we: 1'b0, flag: 1'b0};
        stk     = '{push: 1'b0, pop: 1'b0, data: seq};
        idx     = index;
        dt      = delay;
        sdt     = sound;

        case (major)
            OP_SYS: begin
                if (ins == INS_CLS) begin
                    st = c8ie_pkg::ST_EXTERNAL;
                end else if (ins == INS_RET) begin
                    if (depth == '0) begin
                        st = c8ie_pkg::ST_UNDERFLOW;
                    end else begin
                        stk.pop = 1'b1;
                        npc     = top;
                    end
                end else if (!((nnn > SYS_LOW) && (nnn < SYS_HIGH))) begin
                    st = c8ie_pkg::ST_INVALID;
                end
            end
            OP_JP: npc = nnn;
            OP_CALL: begin
                if (depth >= DW'(STACK_DEPTH)) begin
                    st = c8ie_pkg::ST_OVERFLOW;
                end else begin
                    stk.push = 1'b1;
                    npc      = nnn;
                end
            end
            OP_SE_IMM:  skip = (vx == kk);
            OP_SNE_IMM: skip = (vx != kk);
            OP_SE_REG: begin
                if (n != 4'h0) st = c8ie_pkg::ST_INVALID;
                else skip = (vx == vy);
            end
            OP_LD_IMM: begin
                rf.we   = 1'b1;
                rf.data = kk;
            end
            OP_ADD_IMM: begin
                rf.we   = 1'b1;
                rf.data = vx + kk;
            end
            OP_ALU: begin
                rf.we = 1'b1;
                case (n)
                    ALU_LD:  rf.data = vy;
                    ALU_OR:  rf.data = vx | vy;
                    ALU_AND: rf.data = vx & vy;
                    ALU_XOR: rf.data = vx ^ vy;
                    ALU_ADD: begin
                        rf.data    = sum[7:0];
                        rf.flag_we = 1'b1;
                        rf.flag    = sum[8];
                    end
                    ALU_SUB: begin
                        rf.data    = vx - vy;
                        rf.flag_we = 1'b1;
                        rf.flag    = (vx > vy);
                    end
                    ALU_SHR: begin
                        rf.data    = {1'b0, vx[7:1]};
                        rf.flag_we = 1'b1;
                        rf.flag    = vx[0];
                    end
                    ALU_SBN: begin
                        rf.data    = vy - vx;
                        rf.flag_we = 1'b1;
                        rf.flag    = (vy > vx);
                    end
                    ALU_SHL: begin
                        rf.data    = {vx[6:0], 1'b0};
                        rf.flag_we = 1'b1;
                        rf.flag    = vx[7];
                    end
                    default: begin
                        rf.we = 1'b0;
                        st    = c8ie_pkg::ST_INVALID;
                    end
                endcase
            end
            OP_SNE_REG: begin
                if (n != 4'h0) st = c8ie_pkg::ST_INVALID;
                else skip = (vx != vy);
            end
            OP_LD_I:  idx = nnn;
            OP_JP_V0: npc = nnn + {4'h0, v0};
            OP_RND: begin
                rf.we   = 1'b1;
                rf.data = item.random_byte & kk;
            end
            OP_DRW: st = c8ie_pkg::ST_EXTERNAL;
            OP_SKP: begin
                case (kk)
                    KK_SKP:  skip = pressed;
                    KK_SKNP: skip = !pressed;
                    default: st = c8ie_pkg::ST_INVALID;
                endcase
            end
            default: begin
                case (kk)
                    KK_LD_DT: begin
                        rf.we   = 1'b1;
                        rf.data = delay;
                    end
                    KK_WR_DT: dt  = vx;
                    KK_WR_ST: sdt = vx;
                    KK_ADD_I: idx = index + {4'h0, vx};
                    KK_KEY, KK_FONT, KK_BCD, KK_STORE, KK_LOAD: st = c8ie_pkg::ST_EXTERNAL;
                    default: st = c8ie_pkg::ST_INVALID;
                endcase
            end
        endcase

        if ((st == c8ie_pkg::ST_INVALID) || (st == c8ie_pkg::ST_OVERFLOW) ||
            (st == c8ie_pkg::ST_UNDERFLOW)) begin
            npc = pc;
        end else if (skip) begin
            npc = pc + 12'd4;
        end

        ex.rf         = rf;
        ex.stk        = stk;
        ex.index_next = idx;
        ex.delay_next = dt;
        ex.sound_next = sdt;
        ex.res.status     = st;
        ex.res.next_pc    = npc;
        ex.res.index_addr = idx;
        if (rf.we && (rf.addr == x)) ex.res.vx_value = rf.data;
        else if (rf.flag_we && (x == 4'hF)) ex.res.vx_value = {7'b0000000, rf.flag};
        else ex.res.vx_value = vx;
        if (rf.we && (rf.addr == y)) ex.res.vy_value = rf.data;
        else if (rf.flag_we && (y == 4'hF)) ex.res.vy_value = {7'b0000000, rf.flag};
        else ex.res.vy_value = vy;
    end

endmodule

[design/chip8_instruction_execute.sv]
// Top level: accepts an instruction, executes it against the state, registers the result.
// Accepted instructions are buffered with their reads; results are registered once executed.
// Throughput: one instruction per cycle unless m_ready stalls the output; set by one register-file
// write and one return-stack access per instruction, with reads issued in the cycle of acceptance.
// Reset: V0-VF, I, timers and stack depth clear at once (per-register valid bits), PC to 0x200;
// return-stack contents are undefined until pushed, so no clearing pass is needed.
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  c8ie_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output c8ie_pkg::out_item_t m_item
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic                b_valid_reg;
    c8ie_pkg::in_item_t  b_item_reg;
    logic                m_valid_reg;
    c8ie_pkg::out_item_t m_item_reg;
    logic [11:0]         pc_reg;
    logic [11:0]         index_reg;
    logic [7:0]          delay_reg;
    logic [7:0]          sound_reg;

    logic                accept;
    logic                fire;
    logic [7:0]          vx;
    logic [7:0]          vy;
    logic [7:0]          v0;
    logic [DW-1:0]       depth;
    logic [11:0]         top;
    c8ie_pkg::exec_t     ex;
    c8ie_pkg::rf_wr_t    rf_wr;
    c8ie_pkg::stk_ctl_t  stk_ctl;

    assign fire    = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !b_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_comb begin
        rf_wr           = ex.rf;
        rf_wr.we        = ex.rf.we && fire;
        rf_wr.flag_we   = ex.rf.flag_we && fire;
        stk_ctl         = ex.stk;
        stk_ctl.push    = ex.stk.push && fire;
        stk_ctl.pop     = ex.stk.pop && fire;
    end

    c8ie_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_x (s_item.instruction[11:8]),
        .rd_addr_y (s_item.instruction[7:4]),
        .wr        (rf_wr),
        .vx        (vx),
        .vy        (vy),
        .v0        (v0)
    );

    c8ie_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .ctl     (stk_ctl),
        .depth   (depth),
        .top     (top)
    );

    c8ie_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .item  (b_item_reg),
        .vx    (vx),
        .vy    (vy),
        .v0    (v0),
        .pc    (pc_reg),
        .index (index_reg),
        .delay (delay_reg),
        .sound (sound_reg),
        .depth (depth),
        .top   (top),
        .ex    (ex)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_item_reg <= s_item;
        end
        if (fire) begin
            m_item_reg <= ex.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            pc_reg      <= c8ie_pkg::PC_RESET;
            index_reg   <= 12'h000;
            delay_reg   <= 8'h00;
            sound_reg   <= 8'h00;
        end else begin
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (fire) begin
                b_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
                pc_reg      <= ex.res.next_pc;
                index_reg   <= ex.index_next;
                delay_reg   <= ex.delay_next;
                sound_reg   <= ex.sound_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[test/chip8_checker.sv]
`timescale 1ns / 1ps
// Opcode codes for the CHIP-8 execute testbench and the checker that predicts and compares results.
package chip8_tb_pkg;

    typedef enum logic [3:0] {
        MAJ_SYS, MAJ_JP, MAJ_CALL, MAJ_SE_IMM, MAJ_SNE_IMM, MAJ_SE_REG, MAJ_LD_IMM, MAJ_ADD_IMM,
        MAJ_ALU, MAJ_SNE_REG, MAJ_LD_I, MAJ_JP_V0, MAJ_RND, MAJ_DRW, MAJ_KEY, MAJ_MISC
    } major_t;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [11:0] SYS_LOW  = 12'h200;
    localparam logic [11:0] SYS_HIGH = 12'hFFE;

    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] MISC_LD_VX_DT = 8'h07;
    localparam logic [7:0] MISC_WAIT_KEY = 8'h0A;
    localparam logic [7:0] MISC_LD_DT    = 8'h15;
    localparam logic [7:0] MISC_LD_ST    = 8'h18;
    localparam logic [7:0] MISC_ADD_I    = 8'h1E;
    localparam logic [7:0] MISC_FONT     = 8'h29;
    localparam logic [7:0] MISC_BCD      = 8'h33;
    localparam logic [7:0] MISC_STORE    = 8'h55;
    localparam logic [7:0] MISC_LOAD     = 8'h65;

    localparam int FLAG_REG = 15;

endpackage

module chip8_checker #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  c8ie_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  c8ie_pkg::out_item_t m_item,
    output int                  fail_count,
    output int                  pending
);

    logic [7:0]  vreg [16];
    logic [11:0] index_reg;
    logic [11:0] pc_reg;
    logic [11:0] call_stack [STACK_DEPTH];
    int          stack_used;
    logic [7:0]  delay_tmr;
    logic [7:0]  sound_tmr;

    c8ie_pkg::out_item_t expected_results [$];
    int                  results_seen;

    task automatic report_mismatch(input string what);
        $display("ERROR: transaction %0d at %0t: %s", results_seen, $realtime, what);
        fail_count++;
    endtask

    function automatic c8ie_pkg::out_item_t execute_instruction(input c8ie_pkg::in_item_t it);
        logic [3:0]          x, y, n;
        logic [7:0]          kk, vx, a, b, r;
        logic [11:0]         nnn, npc;
        logic [8:0]          sum;
        c8ie_pkg::status_t   st;
        logic                skip, alu_ok, pressed;
        c8ie_pkg::out_item_t res;
        x      = it.instruction[11:8];
        y      = it.instruction[7:4];
        n      = it.instruction[3:0];
        kk     = it.instruction[7:0];
        nnn    = it.instruction[11:0];
        npc    = pc_reg + 12'd2;
        st     = c8ie_pkg::ST_OK;
        skip   = 1'b0;
        alu_ok = 1'b1;
        vx     = vreg[x];
        a      = vx;
        b      = vreg[y];
        r      = '0;
        case (chip8_tb_pkg::major_t'(it.instruction[15:12]))
            chip8_tb_pkg::MAJ_SYS: begin
                if (it.instruction == chip8_tb_pkg::OP_CLS) begin
                    st = c8ie_pkg::ST_EXTERNAL;
                end else if (it.instruction == chip8_tb_pkg::OP_RET) begin
                    if (stack_used == 0) begin
                        st = c8ie_pkg::ST_UNDERFLOW;
                    end else begin
                        stack_used--;
                        npc = call_stack[stack_used];
                    end
                end else if (nnn < chip8_tb_pkg::SYS_LOW || nnn > chip8_tb_pkg::SYS_HIGH) begin
                    st = c8ie_pkg::ST_INVALID;
                end
            end
            chip8_tb_pkg::MAJ_JP: npc = nnn;
            chip8_tb_pkg::MAJ_CALL: begin
                if (stack_used >= STACK_DEPTH) begin
                    st = c8ie_pkg::ST_OVERFLOW;
                end else begin
                    call_stack[stack_used] = npc;
                    stack_used++;
                    npc = nnn;
                end
            end
            chip8_tb_pkg::MAJ_SE_IMM:  skip = (vx == kk);
            chip8_tb_pkg::MAJ_SNE_IMM: skip = (vx != kk);
            chip8_tb_pkg::MAJ_SE_REG: begin
                if (n != 4'h0) st = c8ie_pkg::ST_INVALID;
                else skip = (vx == b);
            end
            chip8_tb_pkg::MAJ_LD_IMM:  vreg[x] = kk;
            chip8_tb_pkg::MAJ_ADD_IMM: vreg[x] = vx + kk;
            chip8_tb_pkg::MAJ_ALU: begin
                case (n)
                    chip8_tb_pkg::ALU_LD:  r = b;
                    chip8_tb_pkg::ALU_OR:  r = a | b;
                    chip8_tb_pkg::ALU_AND: r = a & b;
                    chip8_tb_pkg::ALU_XOR: r = a ^ b;
                    chip8_tb_pkg::ALU_ADD: begin
                        sum = {1'b0, a} + {1'b0, b};
                        vreg[chip8_tb_pkg::FLAG_REG] = {7'd0, sum[8]};
                        r = sum[7:0];
                    end
                    chip8_tb_pkg::ALU_SUB: begin
                        vreg[chip8_tb_pkg::FLAG_REG] = {7'd0, a > b};
                        r = a - b;
                    end
                    chip8_tb_pkg::ALU_SHR: begin
                        vreg[chip8_tb_pkg::FLAG_REG] = {7'd0, a[0]};
                        r = a >> 1;
                    end
                    chip8_tb_pkg::ALU_SUBN: begin
                        vreg[chip8_tb_pkg::FLAG_REG] = {7'd0, b > a};
                        r = b - a;
                    end
                    chip8_tb_pkg::ALU_SHL: begin
                        vreg[chip8_tb_pkg::FLAG_REG] = {7'd0, a[7]};
                        r = a << 1;
                    end
                    default: begin
                        st = c8ie_pkg::ST_INVALID;
                        alu_ok = 1'b0;
                    end
                endcase
                if (alu_ok) vreg[x] = r;
            end
            chip8_tb_pkg::MAJ_SNE_REG: begin
                if (n != 4'h0) st = c8ie_pkg::ST_INVALID;
                else skip = (vx != b);
            end
            chip8_tb_pkg::MAJ_LD_I:  index_reg = nnn;
            chip8_tb_pkg::MAJ_JP_V0: npc = nnn + {4'd0, vreg[0]};
            chip8_tb_pkg::MAJ_RND:   vreg[x] = it.random_byte & kk;
            chip8_tb_pkg::MAJ_DRW:   st = c8ie_pkg::ST_EXTERNAL;
            chip8_tb_pkg::MAJ_KEY: begin
                pressed = (vx[7:4] == 4'h0) && it.keys_down[vx[3:0]];
                if (kk == chip8_tb_pkg::KEY_SKP) skip = pressed;
                else if (kk == chip8_tb_pkg::KEY_SKNP) skip = !pressed;
                else st = c8ie_pkg::ST_INVALID;
            end
            default: begin
                case (kk)
                    chip8_tb_pkg::MISC_LD_VX_DT: vreg[x] = delay_tmr;
                    chip8_tb_pkg::MISC_LD_DT:    delay_tmr = vx;
                    chip8_tb_pkg::MISC_LD_ST:    sound_tmr = vx;
                    chip8_tb_pkg::MISC_ADD_I:    index_reg = index_reg + {4'd0, vx};
                    chip8_tb_pkg::MISC_WAIT_KEY, chip8_tb_pkg::MISC_FONT, chip8_tb_pkg::MISC_BCD,
                    chip8_tb_pkg::MISC_STORE, chip8_tb_pkg::MISC_LOAD:
                        st = c8ie_pkg::ST_EXTERNAL;
                    default: st = c8ie_pkg::ST_INVALID;
                endcase
            end
        endcase
        if (st == c8ie_pkg::ST_INVALID || st == c8ie_pkg::ST_OVERFLOW ||
            st == c8ie_pkg::ST_UNDERFLOW) npc = pc_reg;
        else if (skip) npc = pc_reg + 12'd4;
        pc_reg = npc;
        res.status     = st;
        res.next_pc    = npc;
        res.index_addr = index_reg;
        res.vx_value   = vreg[x];
        res.vy_value   = vreg[y];
        return res;
    endfunction

    always @(posedge aclk) begin
        c8ie_pkg::out_item_t want;
        if (!aresetn) begin
            foreach (vreg[i]) vreg[i] = '0;
            index_reg    = '0;
            pc_reg       = c8ie_pkg::PC_RESET;
            stack_used   = 0;
            delay_tmr    = '0;
            sound_tmr    = '0;
            results_seen = 0;
            fail_count   = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_item));
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_item.status, want.status));
                    if (m_item.next_pc !== want.next_pc)
                        report_mismatch($sformatf("next_pc got %h want %h",
                                                  m_item.next_pc, want.next_pc));
                    if (m_item.index_addr !== want.index_addr)
                        report_mismatch($sformatf("index_addr got %h want %h",
                                                  m_item.index_addr, want.index_addr));
                    if (m_item.vx_value !== want.vx_value)
                        report_mismatch($sformatf("vx_value got %h want %h",
                                                  m_item.vx_value, want.vx_value));
                    if (m_item.vy_value !== want.vy_value)
                        report_mismatch($sformatf("vy_value got %h want %h",
                                                  m_item.vy_value, want.vy_value));
                end
                results_seen++;
            end
            if (s_valid && s_ready) expected_results.push_back(execute_instruction(s_item));
        end
        pending = expected_results.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: drives instruction streams into the CHIP-8 execute block and gives the verdict.
module tb_top;

    localparam int ITEM_TARGET   = 850;
    localparam int SETTLE_CYCLES = 10;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    c8ie_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    c8ie_pkg::out_item_t m_item;

    int        fail_count;
    int        pending;
    int        items_sent = 0;
    int        rcv_hold   = 0;
    bit        no_idle    = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    chip8_instruction_execute u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    chip8_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // stall the result channel for a drawn number of cycles after each transaction
    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rcv_hold <= 0;
        end else if (m_ready) begin
            if (m_valid) begin
                stall = no_idle ? 0 : $urandom_range(0, 19);
                m_ready  <= (stall == 0);
                rcv_hold <= stall;
            end
        end else if (rcv_hold <= 1) begin
            m_ready  <= 1'b1;
            rcv_hold <= 0;
        end else begin
            rcv_hold <= rcv_hold - 1;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 15));
            1:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] random_alu_code();
        case ($urandom_range(0, 9))
            0:       return chip8_tb_pkg::ALU_LD;
            1:       return chip8_tb_pkg::ALU_OR;
            2:       return chip8_tb_pkg::ALU_AND;
            3:       return chip8_tb_pkg::ALU_XOR;
            4:       return chip8_tb_pkg::ALU_ADD;
            5:       return chip8_tb_pkg::ALU_SUB;
            6:       return chip8_tb_pkg::ALU_SHR;
            7:       return chip8_tb_pkg::ALU_SUBN;
            8:       return chip8_tb_pkg::ALU_SHL;
            default: return 4'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_misc_code();
        case ($urandom_range(0, 10))
            0:       return chip8_tb_pkg::MISC_LD_VX_DT;
            1:       return chip8_tb_pkg::MISC_WAIT_KEY;
            2:       return chip8_tb_pkg::MISC_LD_DT;
            3:       return chip8_tb_pkg::MISC_LD_ST;
            4:       return chip8_tb_pkg::MISC_ADD_I;
            5:       return chip8_tb_pkg::MISC_FONT;
            6:       return chip8_tb_pkg::MISC_BCD;
            7:       return chip8_tb_pkg::MISC_STORE;
            8:       return chip8_tb_pkg::MISC_LOAD;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_instruction();
        chip8_tb_pkg::major_t major;
        logic [3:0]           x, y;
        major = chip8_tb_pkg::major_t'($urandom_range(0, 15));
        x     = 4'($urandom);
        y     = 4'($urandom);
        case (major)
            chip8_tb_pkg::MAJ_SYS: begin
                case ($urandom_range(0, 3))
                    0:       return chip8_tb_pkg::OP_CLS;
                    1:       return chip8_tb_pkg::OP_RET;
                    2:       return {chip8_tb_pkg::MAJ_SYS,
                                     12'($urandom_range(chip8_tb_pkg::SYS_LOW,
                                                        chip8_tb_pkg::SYS_HIGH))};
                    default: return {chip8_tb_pkg::MAJ_SYS, 12'($urandom)};
                endcase
            end
            chip8_tb_pkg::MAJ_SE_REG, chip8_tb_pkg::MAJ_SNE_REG:
                return {major, x, y,
                        ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 15)) : 4'h0};
            chip8_tb_pkg::MAJ_ALU:
                return {chip8_tb_pkg::MAJ_ALU, x, y, random_alu_code()};
            chip8_tb_pkg::MAJ_KEY: begin
                case ($urandom_range(0, 4))
                    0, 1:    return {chip8_tb_pkg::MAJ_KEY, x, chip8_tb_pkg::KEY_SKP};
                    2, 3:    return {chip8_tb_pkg::MAJ_KEY, x, chip8_tb_pkg::KEY_SKNP};
                    default: return {chip8_tb_pkg::MAJ_KEY, x, 8'($urandom)};
                endcase
            end
            chip8_tb_pkg::MAJ_MISC:
                return {chip8_tb_pkg::MAJ_MISC, x, random_misc_code()};
            chip8_tb_pkg::MAJ_JP, chip8_tb_pkg::MAJ_CALL, chip8_tb_pkg::MAJ_LD_I,
            chip8_tb_pkg::MAJ_JP_V0, chip8_tb_pkg::MAJ_DRW:
                return {major, 12'($urandom)};
            default:
                return {major, x, pick_byte()};
        endcase
    endfunction

    task automatic send_instruction(input logic [15:0] instr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= '{instruction: instr, random_byte: 8'($urandom), keys_down: 16'($urandom)};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    initial begin
        logic [15:0] directed_ops [$];
        logic [3:0]  reg_a, reg_b;
        int          depth_goal;
        directed_ops = '{
            chip8_tb_pkg::OP_RET, chip8_tb_pkg::OP_CLS,
            {chip8_tb_pkg::MAJ_SYS, chip8_tb_pkg::SYS_LOW},
            {chip8_tb_pkg::MAJ_SYS, chip8_tb_pkg::SYS_HIGH},
            {chip8_tb_pkg::MAJ_SYS, 12'h1FF}, {chip8_tb_pkg::MAJ_SYS, 12'hFFF},
            {chip8_tb_pkg::MAJ_LD_IMM, 4'h0, 8'hFF}, {chip8_tb_pkg::MAJ_LD_IMM, 4'h1, 8'h01},
            {chip8_tb_pkg::MAJ_ALU, 4'h0, 4'h1, chip8_tb_pkg::ALU_ADD},
            {chip8_tb_pkg::MAJ_ALU, 4'h0, 4'h1, chip8_tb_pkg::ALU_SUB},
            {chip8_tb_pkg::MAJ_ALU, 4'h0, 4'h1, chip8_tb_pkg::ALU_SHL},
            {chip8_tb_pkg::MAJ_ALU, 4'hF, 4'h1, chip8_tb_pkg::ALU_SHR},
            {chip8_tb_pkg::MAJ_ALU, 4'h0, 4'h1, chip8_tb_pkg::ALU_SUBN},
            {chip8_tb_pkg::MAJ_ALU, 4'hF, 4'h0, chip8_tb_pkg::ALU_ADD},
            {chip8_tb_pkg::MAJ_SE_REG, 4'h0, 4'h1, 4'h1},
            {chip8_tb_pkg::MAJ_SE_IMM, 4'h0, 8'h00},
            {chip8_tb_pkg::MAJ_CALL, 12'hFFE}, chip8_tb_pkg::OP_RET,
            {chip8_tb_pkg::MAJ_JP_V0, 12'hFFF}, {chip8_tb_pkg::MAJ_LD_I, 12'hFFF},
            {chip8_tb_pkg::MAJ_MISC, 4'h0, chip8_tb_pkg::MISC_ADD_I},
            {chip8_tb_pkg::MAJ_RND, 4'h0, 8'hFF},
            {chip8_tb_pkg::MAJ_DRW, 4'h0, 4'h1, 4'hF},
            {chip8_tb_pkg::MAJ_KEY, 4'h0, chip8_tb_pkg::KEY_SKP},
            {chip8_tb_pkg::MAJ_MISC, 4'h0, chip8_tb_pkg::MISC_LD_DT}
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_ops[i]) send_instruction(directed_ops[i]);
        drain_results();

        while (items_sent < ITEM_TARGET) begin
            no_idle <= ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(20, 40)) send_instruction(random_instruction());
                end
                4, 5: begin
                    // nest calls past the stack limit at times, then unwind one too far at times
                    depth_goal = $urandom_range(1, c8ie_pkg::STACK_DEPTH_DEFAULT + 2);
                    repeat (depth_goal) begin
                        send_instruction({chip8_tb_pkg::MAJ_CALL, 12'($urandom)});
                        if ($urandom_range(0, 2) == 0) send_instruction(random_instruction());
                    end
                    repeat (depth_goal + $urandom_range(0, 1))
                        send_instruction(chip8_tb_pkg::OP_RET);
                end
                6, 7: begin
                    repeat ($urandom_range(4, 10)) begin
                        reg_a = 4'($urandom);
                        send_instruction({chip8_tb_pkg::MAJ_LD_IMM, reg_a,
                                          ($urandom_range(0, 5) == 0) ?
                                          8'($urandom) : 8'($urandom_range(0, 15))});
                        send_instruction({chip8_tb_pkg::MAJ_KEY, reg_a,
                                          ($urandom_range(0, 1) == 0) ?
                                          chip8_tb_pkg::KEY_SKP : chip8_tb_pkg::KEY_SKNP});
                    end
                end
                8: begin
                    repeat ($urandom_range(4, 10)) begin
                        reg_a = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom);
                        reg_b = 4'($urandom);
                        send_instruction({chip8_tb_pkg::MAJ_LD_IMM, reg_a, pick_byte()});
                        send_instruction({chip8_tb_pkg::MAJ_LD_IMM, reg_b, pick_byte()});
                        send_instruction({chip8_tb_pkg::MAJ_ALU, reg_a, reg_b,
                                          random_alu_code()});
                        send_instruction({($urandom_range(0, 1) == 0) ?
                                          chip8_tb_pkg::MAJ_SE_REG : chip8_tb_pkg::MAJ_SNE_REG,
                                          reg_a, reg_b, 4'h0});
                    end
                end
                default: begin
                    repeat (10) send_instruction(16'($urandom));
                end
            endcase
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[chip8_instruction_execute.f]
design/c8ie_pkg.sv
design/c8ie_regfile.sv
design/c8ie_stack.sv
design/c8ie_exec.sv
design/chip8_instruction_execute.sv
test/chip8_checker.sv
test/tb_top.sv
